// File: hdl/masked_pattern_search_defines.svh
// Assertion macros for the masked pattern search block.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef MASKED_PATTERN_SEARCH_DEFINES_SVH
`define MASKED_PATTERN_SEARCH_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("masked_pattern_search: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define MPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("masked_pattern_search: assertion failed");

`endif

// File: hdl/mps_pkg.sv
// Shared types and constants of the masked pattern search block.
// No dependencies; imported by every module of the block.
`default_nettype none

package mps_pkg;

  localparam int REG_BYTES = 16;
  localparam int LEN_W     = 5;
  localparam int ADDR_W    = 6;
  localparam int DATA_W    = 64;

  // Register indexes (paddr[5:3]).
  localparam logic [2:0] REG_BASE_ADDRESS   = 3'd0;
  localparam logic [2:0] REG_PATTERN_LOW    = 3'd1;
  localparam logic [2:0] REG_PATTERN_HIGH   = 3'd2;
  localparam logic [2:0] REG_CARE_MASK      = 3'd3;
  localparam logic [2:0] REG_PATTERN_LENGTH = 3'd4;

  // Search settings handed to the front part.
  typedef struct packed {
    logic [8*REG_BYTES-1:0] pattern;
    logic [REG_BYTES-1:0]   care;
    logic [LEN_W-1:0]       length;
  } cfg_t;

endpackage

`default_nettype wire

// File: hdl/mps_front.sv
// Front part: takes bytes, keeps the window, count and done flag, and
// classifies each byte into a match record. Depends on mps_pkg.
`default_nettype none

module mps_front import mps_pkg::*; #(
  parameter int PATTERN_BYTES = 16,
  parameter int OFFSET_BITS   = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire cfg_t                   cfg_i,
  input  wire logic                   accept_i,
  input  wire logic [7:0]             data_byte_i,
  input  wire logic                   last_i,
  output logic                        res_push_o,
  output logic                        res_found_o,
  output logic [OFFSET_BITS-1:0]      res_offset_o,
  output logic                        done_o
);

  localparam int WIN = (PATTERN_BYTES < REG_BYTES) ? PATTERN_BYTES : REG_BYTES;
  localparam int AW  = $clog2(WIN);

  logic [7:0]             win_q [WIN];
  logic [7:0]             win_d [WIN];
  logic [OFFSET_BITS-1:0] cnt_q, cnt_d, cnt_inc;
  logic                   done_q, done_d;
  logic [LEN_W-1:0]       len;
  logic                   active, match, hit;

  always_comb begin
    if (cfg_i.length == '0) begin
      len = LEN_W'(1);
    end else if (cfg_i.length > LEN_W'(WIN)) begin
      len = LEN_W'(WIN);
    end else begin
      len = cfg_i.length;
    end
  end

  always_comb begin
    win_d[0] = data_byte_i;
    for (int k = 1; k < WIN; k++) begin
      win_d[k] = win_q[k-1];
    end
  end

  // Pattern byte i is compared with the byte taken len-1-i steps ago.
  always_comb begin
    logic [LEN_W-1:0] age;
    match = 1'b1;
    for (int i = 0; i < WIN; i++) begin
      age = len - LEN_W'(1) - LEN_W'(i);
      if ((LEN_W'(i) < len) && cfg_i.care[i] &&
          (win_d[age[AW-1:0]] != cfg_i.pattern[8*i +: 8])) begin
        match = 1'b0;
      end
    end
  end

  assign cnt_inc = cnt_q + OFFSET_BITS'(1);
  assign active  = !done_q && !(&cnt_q);
  assign hit     = active && (cnt_inc >= OFFSET_BITS'(len)) && match;

  assign res_push_o   = accept_i && (hit || (last_i && !done_q));
  assign res_found_o  = hit;
  assign res_offset_o = cnt_inc - OFFSET_BITS'(len);
  assign done_o       = done_q;

  always_comb begin
    cnt_d  = cnt_q;
    done_d = done_q;
    if (accept_i) begin
      if (last_i) begin
        cnt_d  = '0;
        done_d = 1'b0;
      end else if (active) begin
        cnt_d  = cnt_inc;
        done_d = hit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // Window entries are only compared once enough bytes are counted.
  always_ff @(posedge clk_i) begin
    if (accept_i && active) begin
      win_q <= win_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/mps_fifo.sv
// Short register queue between the front and back parts.
// Depends on mps_pkg only by convention of the project.
`default_nettype none

module mps_fifo import mps_pkg::*; #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  empty_o,
  output logic                  full_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CW'(DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// File: hdl/mps_back.sv
// Back part: turns a match record into a result address and holds it in
// the output register until it is popped. Depends on mps_pkg.
`default_nettype none

module mps_back import mps_pkg::*; #(
  parameter int OFFSET_BITS = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [63:0]          base_i,
  input  wire logic                 q_empty_i,
  input  wire logic                 q_found_i,
  input  wire logic [OFFSET_BITS-1:0] q_offset_i,
  output logic                      q_pop_o,
  input  wire logic                 pop_i,
  output logic                      empty_o,
  output logic                      found_o,
  output logic [63:0]               match_address_o
);

  logic        valid_q, valid_d;
  logic        found_q;
  logic [63:0] addr_q, addr_d;
  logic        load;

  assign load    = !q_empty_i && (!valid_q || pop_i);
  assign q_pop_o = load;
  assign addr_d  = q_found_i ? (base_i + 64'(q_offset_i)) : '0;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      found_q <= q_found_i;
      addr_q  <= addr_d;
    end
  end

  assign empty_o         = !valid_q;
  assign found_o         = found_q;
  assign match_address_o = addr_q;

endmodule

`default_nettype wire

// File: hdl/masked_pattern_search.sv
// Top level of the masked pattern search block: register file, front,
// queue and back part. Depends on mps_pkg, mps_front, mps_fifo, mps_back.
//
// Usage: the bytes of a region stream in through push/full, one transaction
// per byte, with last marking the final byte. The block reports at most one
// result per region on the empty/pop side: found with the base address plus
// the offset of the first match, or not-found with address 0 when the region
// ends without a match. Bytes after a match are dropped until the last byte.
// Throughput is one byte per cycle while full is low: the front compares the
// whole window in the accepting cycle. A result is registered first into the
// two-entry queue, then through the 64-bit address adder into the output
// register. When the receiver stalls, the result holds in the output register
// and the queue absorbs the next two; full rises once both queue entries are
// occupied, so up to three results wait in all, and while full is high no
// byte is taken at all. The APB port writes the settings, which should change
// only while no region is in flight. Reset clears the region state and the
// queue, empties the output register and returns the registers to zero, with
// the pattern length at one.
`default_nettype none

`include "masked_pattern_search_defines.svh"

module masked_pattern_search import mps_pkg::*; #(
  parameter int PATTERN_BYTES = 16,
  parameter int OFFSET_BITS   = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic              last_i,
  output logic                   empty,
  input  wire logic              pop,
  output logic                   found_o,
  output logic [63:0]            match_address_o
);

  localparam int QUEUE_DEPTH = 2;
  localparam int REC_W       = OFFSET_BITS + 1;

  logic [63:0]      base_q, pat_lo_q, pat_hi_q;
  logic [15:0]      care_q;
  logic [LEN_W-1:0] len_q;
  logic [2:0]       reg_idx;
  logic             wr_en;
  cfg_t             cfg;

  logic                   accept;
  logic                   res_push, res_found, front_done;
  logic [OFFSET_BITS-1:0] res_offset;
  logic [REC_W-1:0]       q_rd_data;
  logic                   q_empty, q_full, q_pop;

  // Register file. Each register sits at byte address 8*index.
  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      care_q   <= '0;
      len_q    <= LEN_W'(1);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_BASE_ADDRESS:   base_q   <= pwdata;
        REG_PATTERN_LOW:    pat_lo_q <= pwdata;
        REG_PATTERN_HIGH:   pat_hi_q <= pwdata;
        REG_CARE_MASK:      care_q   <= pwdata[15:0];
        REG_PATTERN_LENGTH: len_q    <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BASE_ADDRESS:   prdata = base_q;
      REG_PATTERN_LOW:    prdata = pat_lo_q;
      REG_PATTERN_HIGH:   prdata = pat_hi_q;
      REG_CARE_MASK:      prdata = DATA_W'(care_q);
      REG_PATTERN_LENGTH: prdata = DATA_W'(len_q);
      default:            prdata = '0;
    endcase
  end

  assign cfg.pattern = {pat_hi_q, pat_lo_q};
  assign cfg.care    = care_q;
  assign cfg.length  = len_q;

  // A byte is taken whenever the queue has room for the record it may cause.
  assign full   = q_full;
  assign accept = push && !full;

  mps_front #(
    .PATTERN_BYTES (PATTERN_BYTES),
    .OFFSET_BITS   (OFFSET_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .accept_i     (accept),
    .data_byte_i  (data_byte_i),
    .last_i       (last_i),
    .res_push_o   (res_push),
    .res_found_o  (res_found),
    .res_offset_o (res_offset),
    .done_o       (front_done)
  );

  mps_fifo #(
    .WIDTH (REC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  ({res_found, res_offset}),
    .pop_i   (q_pop),
    .data_o  (q_rd_data),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  mps_back #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .base_i          (base_q),
    .q_empty_i       (q_empty),
    .q_found_i       (q_rd_data[REC_W-1]),
    .q_offset_i      (q_rd_data[OFFSET_BITS-1:0]),
    .q_pop_o         (q_pop),
    .pop_i           (pop),
    .empty_o         (empty),
    .found_o         (found_o),
    .match_address_o (match_address_o)
  );

  // A not-found result always carries address zero.
  `MPS_ASSERT_NOW(a_notfound_zero, clk_i, rst_ni, !empty && !found_o, match_address_o == '0)
  // After a match, only the last byte of the region may produce a record.
  `MPS_ASSERT_NOW(a_quiet_after_match, clk_i, rst_ni, accept && front_done && !last_i, !res_push)
  // A record is never offered to a full queue.
  `MPS_ASSERT_NOW(a_no_overflow, clk_i, rst_ni, res_push, !q_full)
  // A last byte always leaves the region state cleared.
  `MPS_ASSERT_NEXT(a_region_clear, clk_i, rst_ni, accept && last_i, !front_done)

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench for masked_pattern_search: directed and random byte regions.
// Depends on mps_pkg and the masked_pattern_search RTL only.
// The expected search results come from a behavioral predictor inside this file.

module tb_top import mps_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD    = 20;
  localparam int RESET_CYCLES  = 7;
  localparam int WINDOW_BYTES  = 16;
  localparam int COUNT_BITS    = 32;
  // Margin for a result to pass from its byte through the queue and the output register, and a bit more.
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 400000;
  // Bytes a single random setting may send before it is retired.
  localparam int SETTING_ITEM_CAP = 400;
  localparam int SETTING_SCAN_GOAL = 110;

  // Register indexes above the last real one must be ignored by the block.
  localparam int REG_INDEX_COUNT = 8;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic        found;
    logic [63:0] address;
  } search_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte_i = '0;
  logic        last_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic        found_o;
  logic [63:0] match_address_o;

  // Search results that the predictor says are still owed by the block, oldest first.
  search_result_t expected_results[$];

  // Settings as the testbench believes the block holds them.
  logic [63:0]  base_q = '0;
  logic [127:0] pattern_q = '0;
  logic [15:0]  care_q = '0;
  logic [4:0]   length_q = 5'd1;

  // Region state of the predictor; byte_window[0] is the newest byte.
  logic [7:0]            byte_window[WINDOW_BYTES];
  logic [COUNT_BITS-1:0] bytes_seen_q = '0;
  logic                  match_done_q = 1'b0;

  int send_gap_pct = 0;
  int pop_stall_pct = 0;
  int bytes_scanned = 0;
  int error_count = 0;
  int cycle_count = 0;

  masked_pattern_search i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .push            (push),
    .full            (full),
    .data_byte_i     (data_byte_i),
    .last_i          (last_i),
    .empty           (empty),
    .pop             (pop),
    .found_o         (found_o),
    .match_address_o (match_address_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // A length of zero acts as one; anything past the window acts as a full window.
  function automatic int active_length();
    int n;
    n = length_q;
    if (n == 0) n = 1;
    if (n > WINDOW_BYTES) n = WINDOW_BYTES;
    return n;
  endfunction

  // Pattern byte i lines up with the byte that arrived len-1-i bytes ago.
  function automatic bit match_window(input int len);
    for (int i = 0; i < len; i++) begin
      if (care_q[i] && byte_window[len - 1 - i] != pattern_q[8*i +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void clear_region();
    for (int k = 0; k < WINDOW_BYTES; k++) byte_window[k] = '0;
    bytes_seen_q = '0;
    match_done_q = 1'b0;
  endfunction

  function automatic void store_register(input logic [2:0] index, input logic [63:0] value);
    case (index)
      REG_BASE_ADDRESS:   base_q = value;
      REG_PATTERN_LOW:    pattern_q[63:0] = value;
      REG_PATTERN_HIGH:   pattern_q[127:64] = value;
      REG_CARE_MASK:      care_q = value[15:0];
      REG_PATTERN_LENGTH: length_q = value[4:0];
      default: ;
    endcase
  endfunction

  // Advances the region state by one accepted byte and queues any result it causes.
  function automatic void scan_byte(input logic [7:0] value, input logic is_last);
    int len;
    search_result_t res;
    if (!match_done_q && bytes_seen_q != COUNT_MAX) begin
      len = active_length();
      for (int k = WINDOW_BYTES - 1; k > 0; k--) byte_window[k] = byte_window[k - 1];
      byte_window[0] = value;
      bytes_seen_q++;
      bytes_scanned++;
      if (bytes_seen_q >= COUNT_BITS'(len) && match_window(len)) begin
        match_done_q = 1'b1;
        res.found = 1'b1;
        res.address = base_q + 64'(bytes_seen_q - COUNT_BITS'(len));
        expected_results.push_back(res);
      end
    end
    if (is_last) begin
      // A match earlier in the region (or on this very byte) already reported.
      if (!match_done_q) begin
        res.found = 1'b0;
        res.address = '0;
        expected_results.push_back(res);
      end
      clear_region();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers and checker
  // ---------------------------------------------------------------------------

  // All stimulus changes on the falling edge; push stays high between back-to-back
  // transactions and drops only during an idle gap or a drain.
  task automatic send_byte(input logic [7:0] value, input logic is_last);
    @(negedge clk_i);
    while ($urandom_range(99) < send_gap_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    data_byte_i <= value;
    last_i <= is_last;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    scan_byte(value, is_last);
  endtask

  // Setup cycle, then access cycle; the register takes the value on the access edge.
  task automatic write_register(input logic [2:0] index, input logic [63:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 3'b000};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    store_register(index, value);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Stops sending and waits until every owed result has been taken. The extra
  // cycles let a byte that caused no result clear the pipeline before any
  // register is touched.
  task automatic drain_results();
    @(negedge clk_i);
    push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // The receiver stalls at random; pop is the only thing this process drives.
  always @(negedge clk_i) begin
    pop <= rst_ni && ($urandom_range(99) >= pop_stall_pct);
  end

  // Each popped transaction is compared with the oldest owed result.
  always @(posedge clk_i) begin : check_results
    search_result_t want;
    if (rst_ni && pop && !empty) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, got found=%0b address=%h",
                 $time, found_o, match_address_o);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (found_o !== want.found) begin
          $display("%0t: found mismatch: expected %0b, got %0b",
                   $time, want.found, found_o);
          error_count++;
        end
        if (match_address_o !== want.address) begin
          $display("%0t: match_address mismatch: expected %h, got %h",
                   $time, want.address, match_address_o);
          error_count++;
        end
      end
    end
  end

  // The run never takes this long when the block keeps up; a hang ends here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("** masked_pattern_search: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset leaves length one with nothing cared about, so the first byte of any
  // region matches at offset zero and the rest of that region is dropped. A
  // region of a single byte then matches on its last byte.
  task automatic test_reset_settings();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hAB, 1'b1);
    drain_results();
  endtask

  // Three-byte pattern with the middle byte a wildcard. The base is all ones so
  // the reported address wraps. A second region holds only a partial pattern at
  // its end, which must not count as a match.
  task automatic test_masked_match();
    write_register(REG_BASE_ADDRESS, 64'hFFFF_FFFF_FFFF_FFFF);
    write_register(REG_PATTERN_LOW, 64'h0000_0000_00A5_00FF);
    write_register(REG_PATTERN_HIGH, 64'h8000_0000_0000_0001);
    write_register(REG_CARE_MASK, 64'h0000_0000_0000_0005);
    write_register(REG_PATTERN_LENGTH, 64'd3);
    send_byte(8'h12, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h77, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    drain_results();
  endtask

  // Length zero behaves as one. Writes to the unused register slots must leave
  // every setting alone. Then a length of 31 saturates to a full window: with
  // no care bits, sixteen bytes match and the match lands on the last byte.
  task automatic test_length_limits();
    write_register(REG_BASE_ADDRESS, 64'h8000_0000_0000_0000);
    write_register(REG_PATTERN_LENGTH, 64'd0);
    for (int i = REG_PATTERN_LENGTH + 1; i < REG_INDEX_COUNT; i++) begin
      write_register(3'(i), '1);
    end
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    drain_results();
    write_register(REG_CARE_MASK, 64'd0);
    write_register(REG_PATTERN_LENGTH, 64'd31);
    for (int k = 0; k < WINDOW_BYTES; k++) begin
      send_byte(8'($urandom), k == WINDOW_BYTES - 1);
    end
    drain_results();
  endtask

  // Picks a fresh setting; with widest set, the pattern is a full window with
  // every byte cared about.
  task automatic load_random_setting(input bit widest);
    logic [63:0] base;
    logic [15:0] care;
    logic [4:0]  length;
    case ($urandom_range(3))
      0: base = '0;
      1: base = '1 - 64'($urandom_range(0, 63));
      default: base = {$urandom, $urandom};
    endcase
    case ($urandom_range(7))
      0: care = '0;
      1: care = '1;
      default: care = 16'($urandom);
    endcase
    length = $urandom_range(1) ? 5'($urandom_range(1, 16)) : 5'($urandom_range(0, 31));
    if (widest) begin
      care = '1;
      length = 5'd16;
    end
    write_register(REG_BASE_ADDRESS, base);
    write_register(REG_PATTERN_LOW, {$urandom, $urandom});
    write_register(REG_PATTERN_HIGH, {$urandom, $urandom});
    write_register(REG_CARE_MASK, 64'(care));
    write_register(REG_PATTERN_LENGTH, 64'(length));
  endtask

  // One region of random bytes. Most regions carry the pattern whole at a random
  // place (wildcard positions random too); some carry it with a byte flipped or
  // cut off by the region end; the rest are plain noise.
  task automatic stream_region(output int sent);
    logic [7:0] region[$];
    int len;
    int span;
    int pos;
    int kind;
    int flip;
    len = active_length();
    kind = $urandom_range(9);
    span = ($urandom_range(7) == 0) ? $urandom_range(1, 64) : len + $urandom_range(0, 20);
    for (int k = 0; k < span; k++) region.push_back(8'($urandom));
    if (kind < 8) begin
      if (kind < 6 && span >= len) pos = $urandom_range(0, span - len);
      else pos = $urandom_range(0, span - 1);
      for (int j = 0; j < len; j++) begin
        if (pos + j < span && care_q[j]) region[pos + j] = pattern_q[8*j +: 8];
      end
      if (kind >= 6) begin
        flip = pos + $urandom_range(0, len - 1);
        if (flip < span) region[flip] = region[flip] ^ 8'($urandom_range(1, 255));
      end
    end
    for (int k = 0; k < span; k++) send_byte(region[k], k == span - 1);
    sent = span;
  endtask

  // Random regions under one idle profile; only bytes that reach the window
  // count toward the goal, and each setting ends idle before the next one.
  task automatic test_random_regions(input int gap_pct, input int stall_pct,
                                     input int scan_goal);
    int phase_start;
    int setting_start;
    int setting_items;
    int sent;
    bit first;
    send_gap_pct = gap_pct;
    pop_stall_pct = stall_pct;
    phase_start = bytes_scanned;
    first = 1'b1;
    while (bytes_scanned - phase_start < scan_goal) begin
      load_random_setting(first);
      first = 1'b0;
      setting_start = bytes_scanned;
      setting_items = 0;
      while (bytes_scanned - setting_start < SETTING_SCAN_GOAL &&
             setting_items < SETTING_ITEM_CAP) begin
        stream_region(sent);
        setting_items += sent;
      end
      drain_results();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    clear_region();
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_settings();
    test_masked_match();
    test_length_limits();
    test_random_regions(11, 66, 450);
    test_random_regions(66, 11, 450);
    test_random_regions(0, 0, 450);

    if (error_count == 0) begin
      $display("** masked_pattern_search: PASSED **");
    end else begin
      $display("** masked_pattern_search: FAILED **");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/mps_pkg.sv
hdl/mps_front.sv
hdl/mps_fifo.sv
hdl/mps_back.sv
hdl/masked_pattern_search.sv
tb/sv/tb_top.sv
